// ===== hw/rtl/sld_pkg.sv =====
package sld_pkg;

    // field and datapath widths
    localparam int CODE_W      = 8;
    localparam int LIN_W       = 16;
    localparam int PROD_W      = 30;
    localparam int SUM3_W      = 32;
    localparam int NUM_W       = 34;
    localparam int XYZ_W       = 17;
    localparam int DIV_STAGES  = 3;
    localparam int HALF_W      = 17;
    localparam int RCP_W       = 34;
    localparam int QS_W        = 68;
    localparam int CBRT_STAGES = 21;
    localparam int CBRT_W      = 66;
    localparam int CBRT_SHIFT  = 44;
    localparam int F_W         = 21;
    localparam int Y2_W        = 42;
    localparam int F_BITS      = 20;
    localparam int RAW_W       = 32;
    localparam int OUT_W       = 17;

    // cycles from an accepted transaction to Lab values of one color
    localparam int LAB_LAT = 3 + DIV_STAGES + 1 + CBRT_STAGES + 4;

    localparam logic [OUT_W-1:0] OUT_MAX = '1;

    // rgb to xyz, rows x, y, z
    localparam logic [13:0] XYZ_COEF [3][3] = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };
    localparam logic [3:0]  XYZ_SCALE [3] = '{4'd10, 4'd1, 4'd10};
    localparam logic [16:0] XYZ_RND   [3] = '{17'd47523, 17'd5000, 17'd54441};
    localparam logic [16:0] XYZ_DIV   [3] = '{17'd95047, 17'd10000, 17'd108883};

    // white point division as multiply by ceil(2^k/d), exact for dividends below 2^33
    localparam int XYZ_RSH [3] = '{50, 47, 50};

    function automatic logic [RCP_W-1:0] recip_ceil(input logic [16:0] d, input int k);
        return RCP_W'(((64'd1 << k) + 64'(d) - 64'd1) / 64'(d));
    endfunction

    localparam logic [RCP_W-1:0] XYZ_RECIP [3] = '{
        recip_ceil(XYZ_DIV[0], XYZ_RSH[0]),
        recip_ceil(XYZ_DIV[1], XYZ_RSH[1]),
        recip_ceil(XYZ_DIV[2], XYZ_RSH[2])
    };

    // linear segment of the lab companding: round(v*124592/1000) + 16/116
    localparam logic [XYZ_W-1:0] F_KNEE    = 17'd580;
    localparam logic [14:0]      LIN_MUL   = 15'd15574;
    localparam logic [23:0]      LIN_OFS   = 24'd62;
    localparam logic [24:0]      RECIP_125 = 25'd17179870;
    localparam int               RECIP_SH  = 31;
    localparam logic [F_W-1:0]   F_OFS     = 21'd144631;

    typedef logic [LIN_W-1:0] lin_table_t [256];

    // srgb decode of one code to q0.16 linear light
    function automatic logic [LIN_W-1:0] lin16(input longint unsigned c);
        longint unsigned t_val;
        longint unsigned t2;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned p;
        longint unsigned v;
        int k;
        if (c <= 64'd10)
        begin
            v = (c * 64'd6553600 + 64'd164730) / 64'd329460;
        end
        else
        begin
            t_val = ((64'd1000 * c + 64'd14025) << 30) / 64'd269025;
            t2 = (t_val * t_val) >> 30;
            lo = 64'd0;
            hi = 64'd1 << 30;
            while (lo < hi)
            begin
                mid = (lo + hi + 64'd1) >> 1;
                p = mid;
                for (k = 0; k < 4; k++)
                begin
                    p = (p * mid) >> 30;
                end
                if (p <= t2)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 64'd1;
                end
            end
            v = (t2 * lo + (64'd1 << 43)) >> 44;
        end
        if (v > 64'd65535)
        begin
            v = 64'd65535;
        end
        return v[LIN_W-1:0];
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        int i;
        for (i = 0; i < 256; i++)
        begin
            tbl[i] = lin16(longint'(i));
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== hw/rtl/sld_lab.sv =====
module sld_lab #(
    parameter int  FRAC_BITS = 8,
    localparam int LAB_SHIFT = sld_pkg::F_BITS - FRAC_BITS,
    localparam int LAB_W     = 34 - LAB_SHIFT
) (
    input  logic                              clk,
    input  logic                              ce,
    input  logic        [sld_pkg::CODE_W-1:0] red,
    input  logic        [sld_pkg::CODE_W-1:0] green,
    input  logic        [sld_pkg::CODE_W-1:0] blue,
    output logic signed [LAB_W-1:0]           lab_l,
    output logic signed [LAB_W-1:0]           lab_a,
    output logic signed [LAB_W-1:0]           lab_b
);

    localparam int NUM_W  = sld_pkg::NUM_W;
    localparam int XYZ_W  = sld_pkg::XYZ_W;
    localparam int CBRT_W = sld_pkg::CBRT_W;
    localparam int F_W    = sld_pkg::F_W;
    localparam int Y2_W   = sld_pkg::Y2_W;
    localparam int RAW_W  = sld_pkg::RAW_W;
    localparam int HALF_W = sld_pkg::HALF_W;
    localparam int RCP_W  = sld_pkg::RCP_W;
    localparam int QS_W   = sld_pkg::QS_W;
    localparam int CB_N   = sld_pkg::CBRT_STAGES;

    logic [2:0][sld_pkg::LIN_W-1:0]  lin_reg;
    logic [2:0][sld_pkg::PROD_W-1:0] prod_reg [3];
    logic [2:0][NUM_W-1:0]           num_reg;
    logic [2:0][2*HALF_W-1:0]        pp_hh_reg;
    logic [2:0][2*HALF_W-1:0]        pp_hl_reg;
    logic [2:0][2*HALF_W-1:0]        pp_lh_reg;
    logic [2:0][2*HALF_W-1:0]        pp_ll_reg;
    logic [2:0][2*HALF_W-1:0]        dhh_reg;
    logic [2:0][2*HALF_W:0]          dmid_reg;
    logic [2:0][2*HALF_W-1:0]        dll_reg;
    logic [2:0][XYZ_W-1:0]           quo_reg;
    logic [2:0][CBRT_W-1:0]          cbx_reg [CB_N+1];
    logic [2:0][F_W-1:0]             cby_reg [CB_N+1];
    logic [2:0][Y2_W-1:0]            cby2_reg [CB_N+1];
    logic [2:0][XYZ_W-1:0]           cbv_reg [CB_N+1];
    logic [2:0][CBRT_W-1:0]          cb_trial [CB_N];
    logic [2:0][23:0]                lin_n_reg;
    logic [2:0][F_W-1:0]             root_reg;
    logic [2:0]                      knee_reg;
    logic [2:0][F_W-1:0]             f_reg;
    logic signed [RAW_W-1:0]         raw_l_reg;
    logic signed [RAW_W-1:0]         raw_a_reg;
    logic signed [RAW_W-1:0]         raw_b_reg;
    logic signed [RAW_W-1:0]         fx_s;
    logic signed [RAW_W-1:0]         fy_s;
    logic signed [RAW_W-1:0]         fz_s;
    logic signed [LAB_W-1:0]         lab_l_reg;
    logic signed [LAB_W-1:0]         lab_a_reg;
    logic signed [LAB_W-1:0]         lab_b_reg;

    // round to the output fraction, half away from zero
    function automatic logic signed [LAB_W-1:0] round_lab(input logic signed [RAW_W-1:0] v);
        logic [RAW_W-1:0] mag;
        logic [RAW_W-1:0] half;
        logic [RAW_W-1:0] q;
        half = RAW_W'(1) << (LAB_SHIFT - 1);
        mag = v[RAW_W-1] ? RAW_W'(-v) : RAW_W'(v);
        q = (mag + half) >> LAB_SHIFT;
        return v[RAW_W-1] ? -$signed(LAB_W'(q)) : $signed(LAB_W'(q));
    endfunction

    // gamma table lookup
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lin_reg[0] <= sld_pkg::LIN_TABLE[red];
            lin_reg[1] <= sld_pkg::LIN_TABLE[green];
            lin_reg[2] <= sld_pkg::LIN_TABLE[blue];
        end
    end

    // matrix products
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= sld_pkg::PROD_W'(lin_reg[c])
                        * sld_pkg::PROD_W'(sld_pkg::XYZ_COEF[r][c]);
                end
            end
        end
    end

    // dividends for the white point normalization
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                num_reg[r] <= NUM_W'(sld_pkg::SUM3_W'(prod_reg[r][0])
                                     + sld_pkg::SUM3_W'(prod_reg[r][1])
                                     + sld_pkg::SUM3_W'(prod_reg[r][2]))
                              * NUM_W'(sld_pkg::XYZ_SCALE[r])
                              + NUM_W'(sld_pkg::XYZ_RND[r]);
            end
        end
    end

    // reciprocal multiply, partial products of the halves
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                pp_hh_reg[r] <= (2*HALF_W)'(num_reg[r][NUM_W-1:HALF_W])
                                * (2*HALF_W)'(sld_pkg::XYZ_RECIP[r][RCP_W-1:HALF_W]);
                pp_hl_reg[r] <= (2*HALF_W)'(num_reg[r][NUM_W-1:HALF_W])
                                * (2*HALF_W)'(sld_pkg::XYZ_RECIP[r][HALF_W-1:0]);
                pp_lh_reg[r] <= (2*HALF_W)'(num_reg[r][HALF_W-1:0])
                                * (2*HALF_W)'(sld_pkg::XYZ_RECIP[r][RCP_W-1:HALF_W]);
                pp_ll_reg[r] <= (2*HALF_W)'(num_reg[r][HALF_W-1:0])
                                * (2*HALF_W)'(sld_pkg::XYZ_RECIP[r][HALF_W-1:0]);
            end
        end
    end

    // cross terms
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                dhh_reg[r]  <= pp_hh_reg[r];
                dmid_reg[r] <= (2*HALF_W+1)'(pp_hl_reg[r]) + (2*HALF_W+1)'(pp_lh_reg[r]);
                dll_reg[r]  <= pp_ll_reg[r];
            end
        end
    end

    // full product and quotient
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                quo_reg[r] <= XYZ_W'(((QS_W'(dhh_reg[r]) << (2 * HALF_W))
                                      + (QS_W'(dmid_reg[r]) << HALF_W)
                                      + QS_W'(dll_reg[r])) >> sld_pkg::XYZ_RSH[r]);
            end
        end
    end

    // cube root setup
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                cbx_reg[0][r]  <= CBRT_W'(quo_reg[r]) << sld_pkg::CBRT_SHIFT;
                cby_reg[0][r]  <= '0;
                cby2_reg[0][r] <= '0;
                cbv_reg[0][r]  <= quo_reg[r];
            end
        end
    end

    // digit-by-digit cube root, one root bit per stage
    for (genvar gi = 0; gi < CB_N; gi++)
    begin : g_cbrt
        localparam int SH = 3 * (CB_N - 1 - gi);
        always_comb
        begin
            for (int r = 0; r < 3; r++)
            begin
                cb_trial[gi][r] = (((CBRT_W'(cby2_reg[gi][r]) << 2)
                                    + (CBRT_W'(cby_reg[gi][r]) << 1)) * CBRT_W'(3)
                                   + CBRT_W'(1)) << SH;
            end
        end
        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    cbv_reg[gi+1][r] <= cbv_reg[gi][r];
                    if (cbx_reg[gi][r] >= cb_trial[gi][r])
                    begin
                        cbx_reg[gi+1][r]  <= cbx_reg[gi][r] - cb_trial[gi][r];
                        cby_reg[gi+1][r]  <= (cby_reg[gi][r] << 1) | F_W'(1);
                        cby2_reg[gi+1][r] <= (cby2_reg[gi][r] << 2)
                                             + (Y2_W'(cby_reg[gi][r]) << 2) + Y2_W'(1);
                    end
                    else
                    begin
                        cbx_reg[gi+1][r]  <= cbx_reg[gi][r];
                        cby_reg[gi+1][r]  <= cby_reg[gi][r] << 1;
                        cby2_reg[gi+1][r] <= cby2_reg[gi][r] << 2;
                    end
                end
            end
        end
    end

    // linear segment, first product
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                lin_n_reg[r] <= 24'(cbv_reg[CB_N][r][9:0]) * 24'(sld_pkg::LIN_MUL)
                                + sld_pkg::LIN_OFS;
                root_reg[r]  <= cby_reg[CB_N][r];
                knee_reg[r]  <= cbv_reg[CB_N][r] > sld_pkg::F_KNEE;
            end
        end
    end

    // linear segment divide by 125 and segment select
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (knee_reg[r])
                begin
                    f_reg[r] <= root_reg[r];
                end
                else
                begin
                    f_reg[r] <= F_W'((49'(lin_n_reg[r]) * 49'(sld_pkg::RECIP_125))
                                     >> sld_pkg::RECIP_SH) + sld_pkg::F_OFS;
                end
            end
        end
    end

    // lab in q.20
    assign fx_s = $signed(RAW_W'(f_reg[0]));
    assign fy_s = $signed(RAW_W'(f_reg[1]));
    assign fz_s = $signed(RAW_W'(f_reg[2]));

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            raw_l_reg <= RAW_W'(116) * fy_s - (RAW_W'(16) <<< sld_pkg::F_BITS);
            raw_a_reg <= RAW_W'(500) * (fx_s - fy_s);
            raw_b_reg <= RAW_W'(200) * (fy_s - fz_s);
        end
    end

    // round to output fraction
    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            lab_l_reg <= round_lab(raw_l_reg);
            lab_a_reg <= round_lab(raw_a_reg);
            lab_b_reg <= round_lab(raw_b_reg);
        end
    end

    assign lab_l = lab_l_reg;
    assign lab_a = lab_a_reg;
    assign lab_b = lab_b_reg;

endmodule

// ===== hw/rtl/srgb_lab_color_distance.sv =====
// throughput: one transaction per cycle while no result is held, every stage is fully pipelined;
// the cube root and square root resolve one result bit per stage
// the whole pipeline holds while a result waits on m_axis_tready
// reset clears the valid bits only; no output until the first result
module srgb_lab_color_distance #(
    parameter int FRAC_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // red_a, green_a, blue_a, red_b, green_b, blue_b
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // delta_e, zero pad
    output logic [23:0] m_axis_tdata
);

    localparam int LAB_SHIFT = sld_pkg::F_BITS - FRAC_BITS;
    localparam int LAB_W     = 34 - LAB_SHIFT;
    localparam int SUM_W     = 2 * LAB_W + 2;
    localparam int SQ_N      = SUM_W / 2;
    localparam int DEPTH     = sld_pkg::LAB_LAT + 4 + SQ_N;
    localparam int OUT_W     = sld_pkg::OUT_W;

    logic                    adv;
    logic [DEPTH-1:0]        vld_reg;
    logic signed [LAB_W-1:0] lab_p [3];
    logic signed [LAB_W-1:0] lab_q [3];
    logic [2:0][LAB_W-1:0]   mag_reg;
    logic [2:0][2*LAB_W-1:0] sq_reg;
    logic [SUM_W-1:0]        srem_reg [SQ_N+1];
    logic [SUM_W-1:0]        sr_reg [SQ_N+1];
    logic [SUM_W-1:0]        dist_round;
    logic [OUT_W-1:0]        dist_next;
    logic [OUT_W-1:0]        dist_reg;

    // pipeline advances unless a result is held
    assign adv = !vld_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = adv;

    sld_lab #(.FRAC_BITS(FRAC_BITS)) u_lab_a (
        .clk   (clk),
        .ce    (adv),
        .red   (s_axis_tdata[7:0]),
        .green (s_axis_tdata[15:8]),
        .blue  (s_axis_tdata[23:16]),
        .lab_l (lab_p[0]),
        .lab_a (lab_p[1]),
        .lab_b (lab_p[2])
    );

    sld_lab #(.FRAC_BITS(FRAC_BITS)) u_lab_b (
        .clk   (clk),
        .ce    (adv),
        .red   (s_axis_tdata[31:24]),
        .green (s_axis_tdata[39:32]),
        .blue  (s_axis_tdata[47:40]),
        .lab_l (lab_q[0]),
        .lab_a (lab_q[1]),
        .lab_b (lab_q[2])
    );

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_axis_tvalid};
        end
    end

    // absolute differences
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (lab_p[c] >= lab_q[c])
                begin
                    mag_reg[c] <= LAB_W'(lab_p[c] - lab_q[c]);
                end
                else
                begin
                    mag_reg[c] <= LAB_W'(lab_q[c] - lab_p[c]);
                end
            end
        end
    end

    // squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sq_reg[c] <= (2*LAB_W)'(mag_reg[c]) * (2*LAB_W)'(mag_reg[c]);
            end
        end
    end

    // sum of squares feeds the root
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            srem_reg[0] <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            sr_reg[0]   <= '0;
        end
    end

    // square root, one result bit per stage
    for (genvar gi = 0; gi < SQ_N; gi++)
    begin : g_sqrt
        localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQ_N - 1 - gi));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (srem_reg[gi] >= sr_reg[gi] + BIT)
                begin
                    srem_reg[gi+1] <= srem_reg[gi] - (sr_reg[gi] + BIT);
                    sr_reg[gi+1]   <= (sr_reg[gi] >> 1) + BIT;
                end
                else
                begin
                    srem_reg[gi+1] <= srem_reg[gi];
                    sr_reg[gi+1]   <= sr_reg[gi] >> 1;
                end
            end
        end
    end

    // round to nearest and saturate
    always_comb
    begin
        dist_round = (srem_reg[SQ_N] > sr_reg[SQ_N]) ? sr_reg[SQ_N] + SUM_W'(1) : sr_reg[SQ_N];
        if (dist_round > SUM_W'(sld_pkg::OUT_MAX))
        begin
            dist_next = sld_pkg::OUT_MAX;
        end
        else
        begin
            dist_next = OUT_W'(dist_round);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dist_reg <= dist_next;
        end
    end

    assign m_axis_tvalid = vld_reg[DEPTH-1];
    assign m_axis_tdata  = {{(24-OUT_W){1'b0}}, dist_reg};

endmodule

// ===== hw/rtl/sld_check.sv =====
module sld_check (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [47:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("held result changed");

    // input side only stalls while the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output back pressure");

    // pad bits above the distance stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:17] == 7'd0)
        else $error("nonzero pad bits");

    // a taken result frees the pipeline in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready |-> s_axis_tready)
        else $error("ready low while result taken");

endmodule

bind srgb_lab_color_distance sld_check u_sld_check (.*);

// ===== dv/tb_top.sv =====
// scoreboard of expected cie76 distances, one per accepted color pair
class delta_e_scoreboard;
    logic [16:0] pending_q[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    // srgb code to q0.16 linear light
    function automatic longint unsigned decode_code(longint unsigned c);
        longint unsigned t_val, t2, lo, hi, mid, p, v;
        int k;
        if (c <= 10)
        begin
            return (c * 6553600 + 164730) / 329460;
        end
        t_val = ((1000 * c + 14025) << 30) / 269025;
        t2 = (t_val * t_val) >> 30;
        lo = 0;
        hi = 64'd1 << 30;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            p = mid;
            for (k = 0; k < 4; k++)
            begin
                p = (p * mid) >> 30;
            end
            if (p <= t2)
            begin
                lo = mid;
            end
            else
            begin
                hi = mid - 1;
            end
        end
        v = (t2 * lo + (64'd1 << 43)) >> 44;
        return (v > 65535) ? 65535 : v;
    endfunction

    // lab companding, q1.20
    function automatic longint compand(longint unsigned v);
        longint unsigned tgt, lo, hi, mid;
        if (v * 1000000 > 64'd8856 * 65536)
        begin
            tgt = v << 44;
            lo = 0;
            hi = (64'd1 << 21) - 1;
            while (lo < hi)
            begin
                mid = (lo + hi + 1) >> 1;
                if (mid * mid * mid <= tgt)
                begin
                    lo = mid;
                end
                else
                begin
                    hi = mid - 1;
                end
            end
            return longint'(lo);
        end
        return longint'((v * 124592 + 500) / 1000) + 144631;
    endfunction

    // q1.20 to q.8, half away from zero
    function automatic longint to_q8(longint v);
        if (v < 0)
        begin
            return -(((-v) + 2048) >>> 12);
        end
        return (v + 2048) >>> 12;
    endfunction

    function automatic void color_to_lab(input logic [23:0] rgb, output longint lab[3]);
        longint unsigned r, g, b, x, y, z;
        longint fx, fy, fz;
        r = decode_code(rgb[7:0]);
        g = decode_code(rgb[15:8]);
        b = decode_code(rgb[23:16]);
        x = ((4124 * r + 3576 * g + 1805 * b) * 10 + 47523) / 95047;
        y = (2126 * r + 7152 * g + 722 * b + 5000) / 10000;
        z = ((193 * r + 1192 * g + 9505 * b) * 10 + 54441) / 108883;
        fx = compand(x);
        fy = compand(y);
        fz = compand(z);
        lab[0] = to_q8(116 * fy - (longint'(16) << 20));
        lab[1] = to_q8(500 * (fx - fy));
        lab[2] = to_q8(200 * (fy - fz));
    endfunction

    function automatic longint unsigned round_sqrt(longint unsigned s);
        longint unsigned r, bit_v, rem;
        r = 0;
        bit_v = 64'd1 << 62;
        rem = s;
        while (bit_v > rem)
        begin
            bit_v >>= 2;
        end
        while (bit_v != 0)
        begin
            if (rem >= r + bit_v)
            begin
                rem -= r + bit_v;
                r = (r >> 1) + bit_v;
            end
            else
            begin
                r >>= 1;
            end
            bit_v >>= 2;
        end
        if (rem > r)
        begin
            r++;
        end
        return r;
    endfunction

    function void note_pair(logic [47:0] pair);
        longint lab_a[3], lab_b[3], diff;
        longint unsigned sum, d;
        sum = 0;
        color_to_lab(pair[23:0], lab_a);
        color_to_lab(pair[47:24], lab_b);
        for (int i = 0; i < 3; i++)
        begin
            diff = lab_a[i] - lab_b[i];
            if (diff < 0)
            begin
                diff = -diff;
            end
            sum += longint'(diff) * diff;
        end
        d = round_sqrt(sum);
        pending_q.push_back((d > 131071) ? 17'h1ffff : d[16:0]);
    endfunction

    function void check_distance(logic [23:0] data);
        logic [16:0] exp_v;
        if (pending_q.size() == 0)
        begin
            $display("%0t: unexpected result %0d", $time, data[16:0]);
            errors++;
            return;
        end
        exp_v = pending_q.pop_front();
        if (data[16:0] !== exp_v || data[23:17] !== 7'd0)
        begin
            $display("%0t: delta_e mismatch expected %0d actual %0d (pad %h)",
                     $time, exp_v, data[16:0], data[23:17]);
            errors++;
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;

    delta_e_scoreboard sb;
    int  cycle_cnt;
    bit  stim_done;
    bit  long_hold;

    srgb_lab_color_distance i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // offer one pair and hold it until the transaction completes
    task automatic send_pair(logic [47:0] pair);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pair;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_pair(pair);
        @(negedge clk);
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic [23:0] rand_color();
        case ($urandom_range(0, 5))
            0: return 24'h000000;
            1: return 24'hffffff;
            2: return {8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
                       8'($urandom_range(0, 12))};
            default: return 24'($urandom);
        endcase
    endfunction

    // stimulus
    initial
    begin
        logic [23:0] ca;
        int burst;
        sb = new();
        stim_done = 0;
        long_hold = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: extremes, knee of the decode curve, primaries, max distance
        send_pair({24'h000000, 24'h000000});
        send_pair({24'hffffff, 24'hffffff});
        send_pair({24'hffffff, 24'h000000});
        send_pair({24'h000000, 24'hffffff});
        send_pair({24'h0a0a0a, 24'h0b0b0b});
        send_pair({24'h0b0b0b, 24'h0a0a0a});
        send_pair({24'h010203, 24'h000000});
        send_pair({24'h0000ff, 24'h00ff00});
        send_pair({24'hff0000, 24'h00ff00});
        send_pair({24'hff0000, 24'h0000ff});
        send_pair({24'hff00ff, 24'h00ff00});
        send_pair({24'h00ffff, 24'hff0000});
        send_pair({24'h000001, 24'h000000});
        send_pair({24'h080808, 24'h090909});
        send_pair({24'h808080, 24'h7f7f7f});
        send_pair({24'haa55aa, 24'h55aa55});
        // back-to-back run while the receiver holds off for a long stretch
        long_hold = 1;
        for (int i = 0; i < 120; i++)
        begin
            send_pair({rand_color(), rand_color()});
        end
        // random bursts with random gaps, some pairs close together
        for (int i = 0; i < 530; )
        begin
            burst = $urandom_range(1, 20);
            for (int j = 0; j < burst; j++)
            begin
                ca = rand_color();
                if ($urandom_range(0, 3) == 0)
                begin
                    send_pair({ca ^ 24'($urandom_range(0, 7)), ca});
                end
                else
                begin
                    send_pair({rand_color(), ca});
                end
                i++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_cycles($urandom_range(1, 8));
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    // receiver stall pattern, with one long hold-off
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 0;
                m_axis_tready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            if (cycle_cnt % 1000 < 300)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_distance(m_axis_tdata);
        end
    end

    // cycle limit
    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > 200000)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // end of run
    initial
    begin
        wait (stim_done);
        while (sb.pending_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (150) @(posedge clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
hw/rtl/sld_pkg.sv
hw/rtl/sld_lab.sv
hw/rtl/srgb_lab_color_distance.sv
hw/rtl/sld_check.sv
dv/tb_top.sv
